@@ src/crosspoint_route_loader_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Crosspoint route loader assertion macros
// Shorthand for clocked checks that are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef CROSSPOINT_ROUTE_LOADER_UNIT_MACROS_SVH
`define CROSSPOINT_ROUTE_LOADER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRL_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CRL_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/crl_pkg.sv @@
// ----------------------------------------------------------------------------
// Crosspoint route loader package
// Shared types, command codes and default geometry of the route loader.
// ----------------------------------------------------------------------------
package crl_pkg;

  // Default geometry: a 2 x 2 array of 16 x 16 switch chips.
  localparam int DEF_CHIP_SIDE      = 16;
  localparam int DEF_ACTIVE_SIDE    = 12;
  localparam int DEF_CHIPS_PER_SIDE = 2;
  localparam int DEF_QUEUE_DEPTH    = 2;

  // The route map is stored in bytes, in the order it is shifted out.
  localparam int BYTE_W = 8;

  // Action codes of an input transaction.
  localparam logic [2:0] ACT_ADD   = 3'd0;
  localparam logic [2:0] ACT_QUERY = 3'd1;
  localparam logic [2:0] ACT_CLEAR = 3'd2;
  localparam logic [2:0] ACT_FLUSH = 3'd3;
  localparam logic [2:0] ACT_TICK  = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ADD,
    OP_QUERY,
    OP_CLEAR,
    OP_FLUSH,
    OP_TICK
  } op_t;

  typedef struct packed {
    logic [2:0] action;
    logic [4:0] col_index;
    logic [4:0] row_index;
  } cmd_item_t;

  typedef struct packed {
    logic routed;
    logic busy_res;
    logic rejected;
    logic serial_clock;
    logic serial_data;
    logic latch_clock;
  } result_item_t;

  // Decoded command as it travels from the front end to the back end.
  typedef struct packed {
    op_t  op;
    logic on_grid;
  } cmd_ctl_t;

endpackage

@@ src/crl_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module crl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/crl_fifo.sv @@
// ----------------------------------------------------------------------------
// Small register queue
// First-in first-out buffer of a few entries built from flip-flops.
// ----------------------------------------------------------------------------
module crl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr + 1'b1);
      end
      case ({do_push, do_pop})
        2'b10: count <= CNT_W'(count + 1'b1);
        2'b01: count <= CNT_W'(count - 1'b1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/crl_front.sv @@
// ----------------------------------------------------------------------------
// Route loader front end
// Accepts transactions, decodes the action and maps the crosspoint to its
// bit position in the map, then queues the decoded command.
// ----------------------------------------------------------------------------
module crl_front #(
  parameter int CHIP_SIDE      = 16,
  parameter int CHIPS_PER_SIDE = 2,
  parameter int QUEUE_DEPTH    = 2,
  localparam int POS_W = $clog2(CHIP_SIDE * CHIP_SIDE * CHIPS_PER_SIDE * CHIPS_PER_SIDE)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  crl_pkg::cmd_item_t  cmd,
  input  logic                hold,
  output logic                q_valid,
  output crl_pkg::cmd_ctl_t   q_ctl,
  output logic [POS_W-1:0]    q_pos,
  input  logic                q_pop
);

  import crl_pkg::*;

  localparam int GRID_SIDE = CHIP_SIDE * CHIPS_PER_SIDE;
  localparam int CHIP_BITS = CHIP_SIDE * CHIP_SIDE;
  localparam int CW        = (CHIPS_PER_SIDE > 1) ? $clog2(CHIPS_PER_SIDE) : 1;
  localparam int LW        = $clog2(CHIP_SIDE);
  localparam int ENTRY_W   = $bits(cmd_ctl_t) + POS_W;

  cmd_ctl_t           ctl;
  logic [CW-1:0]      chip_x;
  logic [CW-1:0]      chip_y;
  logic [LW-1:0]      loc_col;
  logic [LW-1:0]      loc_row;
  logic [POS_W-1:0]   pos;
  logic               q_full;
  logic               q_empty;
  logic [ENTRY_W-1:0] q_data;

  always_comb begin
    case (cmd.action)
      ACT_ADD:   ctl.op = OP_ADD;
      ACT_QUERY: ctl.op = OP_QUERY;
      ACT_CLEAR: ctl.op = OP_CLEAR;
      ACT_FLUSH: ctl.op = OP_FLUSH;
      ACT_TICK:  ctl.op = OP_TICK;
      default:   ctl.op = OP_NOP;
    endcase
    ctl.on_grid = (int'(cmd.col_index) < GRID_SIDE) && (int'(cmd.row_index) < GRID_SIDE);
  end

  // Chip coordinates come from a few independent threshold compares.
  always_comb begin
    chip_x = '0;
    chip_y = '0;
    for (int k = 1; k < CHIPS_PER_SIDE; k++) begin
      if (int'(cmd.col_index) >= k * CHIP_SIDE) begin
        chip_x = CW'(k);
      end
      if (int'(cmd.row_index) >= k * CHIP_SIDE) begin
        chip_y = CW'(k);
      end
    end
  end

  assign loc_col = LW'(int'(cmd.col_index) - int'(chip_x) * CHIP_SIDE);
  assign loc_row = LW'(int'(cmd.row_index) - int'(chip_y) * CHIP_SIDE);
  assign pos     = POS_W'((int'(chip_y) * CHIPS_PER_SIDE + int'(chip_x)) * CHIP_BITS
                          + int'(loc_row) * CHIP_SIDE + int'(loc_col));

  assign full    = q_full || hold;
  assign q_valid = !q_empty;

  crl_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && !hold),
    .din   ({ctl, pos}),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_data),
    .empty (q_empty)
  );

  assign {q_ctl, q_pos} = q_data;

endmodule

@@ src/crl_back.sv @@
// ----------------------------------------------------------------------------
// Route loader back end
// Executes decoded commands against the route map RAM, runs the clearing
// sweeps and the serial flush sequencer, and produces one result per command.
// ----------------------------------------------------------------------------
module crl_back #(
  parameter int CHIP_SIDE      = 16,
  parameter int ACTIVE_SIDE    = 12,
  parameter int CHIPS_PER_SIDE = 2,
  localparam int POS_W = $clog2(CHIP_SIDE * CHIP_SIDE * CHIPS_PER_SIDE * CHIPS_PER_SIDE)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic                  cfg_data,
  input  logic                  cmd_valid,
  input  crl_pkg::cmd_ctl_t     cmd_ctl,
  input  logic [POS_W-1:0]      cmd_pos,
  output logic                  cmd_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output crl_pkg::result_item_t res_data,
  output logic                  sweeping
);

  import crl_pkg::*;

  localparam int TOTAL_BITS = CHIP_SIDE * CHIP_SIDE * CHIPS_PER_SIDE * CHIPS_PER_SIDE;
  localparam int N_BYTES    = (TOTAL_BITS + BYTE_W - 1) / BYTE_W;
  localparam int AW         = POS_W - 3;
  localparam int LW         = $clog2(CHIP_SIDE);

  typedef enum logic [3:0] {
    BK_CLEAR  = 4'b0001,
    BK_RUN    = 4'b0010,
    BK_ACCESS = 4'b0100,
    BK_MASK   = 4'b1000
  } back_state_t;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_PRESET = 6'b000010,
    PH_ZEROS  = 6'b000100,
    PH_LATCH1 = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_LATCH2 = 6'b100000
  } flush_phase_t;

  back_state_t  state, state_next;
  flush_phase_t phase, phase_next, st_phase;
  logic [POS_W-1:0] bit_count, bit_count_next, st_bit_count;
  logic [1:0]   write_step, write_step_next, st_write_step;
  logic         sclk, sclk_next, st_sclk;
  logic         sdata, sdata_next, st_sdata;
  logic         latch, latch_next, st_latch;
  logic         link_enabled;
  logic         count_done;
  logic         busy;

  logic [AW-1:0] sweep_addr, sweep_addr_next;
  logic [AW-1:0] wr_addr;
  logic          rd_done, rd_done_next;
  logic          wr_pending, wr_pending_next;
  logic [LW-1:0] base_row, base_col, base_row_step, base_col_step;
  logic [BYTE_W-1:0] keep_mask;

  logic          start_access;
  logic          pend_add;
  logic [2:0]    pend_bit;
  logic [AW-1:0] pend_addr;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;

  logic routed;
  logic rejected;

  assign busy       = (phase != PH_IDLE);
  assign count_done = (bit_count == POS_W'(TOTAL_BITS - 1));
  assign sweeping   = (state == BK_CLEAR);

  // One write of the serial pin sequence.
  always_comb begin
    st_phase      = phase;
    st_bit_count  = bit_count;
    st_write_step = write_step;
    st_sclk       = sclk;
    st_sdata      = sdata;
    st_latch      = latch;
    case (phase)
      PH_PRESET: begin
        st_sdata      = 1'b0;
        st_phase      = PH_ZEROS;
        st_write_step = 2'd0;
        st_bit_count  = '0;
      end
      PH_ZEROS: begin
        st_sclk = (write_step < 2'd2);
        if (write_step == 2'd3) begin
          st_write_step = 2'd0;
          if (count_done) begin
            st_bit_count = '0;
            st_phase     = PH_LATCH1;
          end else begin
            st_bit_count = POS_W'(bit_count + 1'b1);
          end
        end else begin
          st_write_step = 2'(write_step + 1'b1);
        end
      end
      PH_LATCH1, PH_LATCH2: begin
        if (write_step == 2'd0) begin
          st_latch      = 1'b0;
          st_write_step = 2'd1;
        end else begin
          st_latch      = 1'b1;
          st_write_step = 2'd0;
          st_bit_count  = '0;
          st_phase      = (phase == PH_LATCH1) ? PH_DATA : PH_IDLE;
        end
      end
      PH_DATA: begin
        if (write_step == 2'd0) begin
          // Each byte goes out with its highest bit first.
          st_sdata      = ram_rdata[~bit_count[2:0]];
          st_write_step = 2'd1;
        end else if (write_step < 2'd3) begin
          st_sclk       = 1'b1;
          st_write_step = 2'(write_step + 1'b1);
        end else begin
          st_sclk       = 1'b0;
          st_write_step = 2'd0;
          if (count_done) begin
            st_bit_count = '0;
            st_phase     = PH_LATCH2;
          end else begin
            st_bit_count = POS_W'(bit_count + 1'b1);
          end
        end
      end
      default: st_phase = PH_IDLE;
    endcase
  end

  // Walks the eight map positions of one byte, marking those whose local row
  // and column both lie below the active side, and finds the next byte base.
  always_comb begin
    logic [LW-1:0] r;
    logic [LW-1:0] c;
    r = base_row;
    c = base_col;
    for (int j = 0; j < BYTE_W; j++) begin
      keep_mask[j] = (int'(r) < ACTIVE_SIDE) && (int'(c) < ACTIVE_SIDE);
      if (c == LW'(CHIP_SIDE - 1)) begin
        c = '0;
        r = (r == LW'(CHIP_SIDE - 1)) ? '0 : LW'(r + 1'b1);
      end else begin
        c = LW'(c + 1'b1);
      end
    end
    base_row_step = r;
    base_col_step = c;
  end

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    bit_count_next  = bit_count;
    write_step_next = write_step;
    sclk_next       = sclk;
    sdata_next      = sdata;
    latch_next      = latch;
    sweep_addr_next = sweep_addr;
    rd_done_next    = rd_done;
    wr_pending_next = 1'b0;
    start_access    = 1'b0;
    cmd_pop         = 1'b0;
    res_push        = 1'b0;
    routed          = 1'b0;
    rejected        = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = pend_addr;
    ram_wdata       = '0;
    case (state)
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr;
        if (sweep_addr == AW'(N_BYTES - 1)) begin
          sweep_addr_next = '0;
          state_next      = BK_RUN;
        end else begin
          sweep_addr_next = AW'(sweep_addr + 1'b1);
        end
      end
      BK_MASK: begin
        // Read one byte per cycle, write it back masked in the cycle after.
        if (!rd_done) begin
          wr_pending_next = 1'b1;
          if (sweep_addr == AW'(N_BYTES - 1)) begin
            rd_done_next = 1'b1;
          end else begin
            sweep_addr_next = AW'(sweep_addr + 1'b1);
          end
        end
        if (wr_pending) begin
          ram_we    = 1'b1;
          ram_waddr = wr_addr;
          ram_wdata = ram_rdata & keep_mask;
          if (wr_addr == AW'(N_BYTES - 1)) begin
            state_next = BK_RUN;
          end
        end
      end
      BK_ACCESS: begin
        res_push = 1'b1;
        if (pend_add) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | (BYTE_W'(1) << pend_bit);
        end else begin
          routed = ram_rdata[pend_bit];
        end
        state_next = BK_RUN;
      end
      BK_RUN: begin
        if (cmd_valid && !res_full) begin
          cmd_pop  = 1'b1;
          res_push = 1'b1;
          case (cmd_ctl.op)
            OP_TICK: begin
              if (busy) begin
                phase_next      = st_phase;
                bit_count_next  = st_bit_count;
                write_step_next = st_write_step;
                sclk_next       = st_sclk;
                sdata_next      = st_sdata;
                latch_next      = st_latch;
              end
            end
            OP_ADD, OP_QUERY: begin
              if (busy) begin
                rejected = 1'b1;
              end else if (cmd_ctl.on_grid) begin
                res_push     = 1'b0;
                start_access = 1'b1;
                state_next   = BK_ACCESS;
              end
            end
            OP_CLEAR: begin
              if (busy) begin
                rejected = 1'b1;
              end else begin
                sweep_addr_next = '0;
                state_next      = BK_CLEAR;
              end
            end
            OP_FLUSH: begin
              if (busy || !link_enabled) begin
                rejected = 1'b1;
              end else begin
                phase_next      = PH_PRESET;
                bit_count_next  = '0;
                write_step_next = 2'd0;
                sweep_addr_next = '0;
                rd_done_next    = 1'b0;
                state_next      = BK_MASK;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_next = BK_RUN;
    endcase
  end

  // During a flush the port follows the byte of the next bit, so the byte is
  // already registered when its first data write comes.
  always_comb begin
    if (state == BK_MASK) begin
      ram_raddr = sweep_addr;
    end else if (busy) begin
      ram_raddr = bit_count_next[POS_W-1:3];
    end else begin
      ram_raddr = cmd_pos[POS_W-1:3];
    end
  end

  assign res_data = '{
    routed:       routed,
    busy_res:     (phase_next != PH_IDLE),
    rejected:     rejected,
    serial_clock: sclk_next,
    serial_data:  sdata_next,
    latch_clock:  latch_next
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= BK_CLEAR;
      phase        <= PH_IDLE;
      bit_count    <= '0;
      write_step   <= 2'd0;
      sclk         <= 1'b0;
      sdata        <= 1'b0;
      latch        <= 1'b1;
      link_enabled <= 1'b0;
      sweep_addr   <= '0;
      rd_done      <= 1'b0;
      wr_pending   <= 1'b0;
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      bit_count  <= bit_count_next;
      write_step <= write_step_next;
      sclk       <= sclk_next;
      sdata      <= sdata_next;
      latch      <= latch_next;
      sweep_addr <= sweep_addr_next;
      rd_done    <= rd_done_next;
      wr_pending <= wr_pending_next;
      if (cfg_write) begin
        link_enabled <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= sweep_addr;
    if (state != BK_MASK) begin
      base_row <= '0;
      base_col <= '0;
    end else if (wr_pending) begin
      base_row <= base_row_step;
      base_col <= base_col_step;
    end
    if (start_access) begin
      pend_add  <= (cmd_ctl.op == OP_ADD);
      pend_bit  <= cmd_pos[2:0];
      pend_addr <= cmd_pos[POS_W-1:3];
    end
  end

  crl_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (N_BYTES)
  ) u_map_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ src/crosspoint_route_loader_unit.sv @@
// ----------------------------------------------------------------------------
// Crosspoint route loader
// Keeps the route map of a square array of crosspoint switch chips and
// drives their serial load pins one write per tick during a flush.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Payload
//   -------   ----------------   -----------------------------------------
//   command   push / full        cmd    (action, col_index, row_index)
//   result    pop / empty        result (routed, busy_res, rejected, pins)
//   config    cfg_write          cfg_data (link enable)
//
// A tick, a rejected or idle command and an off-grid add or query finish in
// BK_RUN in the back end; an add or query on the grid goes on to BK_ACCESS,
// as the read of the map RAM is registered. A clear-all and a flush start
// each sweep all ceil(TOTAL_BITS / 8) bytes of the map RAM (128 by default),
// one byte per cycle. After reset the same clearing pass runs while
// full stays high; configuration writes are taken throughout. A two-entry
// queue on each side lets the front end accept while the back end or the
// result consumer stalls.
//
`include "crosspoint_route_loader_unit_macros.svh"

module crosspoint_route_loader_unit #(
  parameter int CHIP_SIDE      = crl_pkg::DEF_CHIP_SIDE,
  parameter int ACTIVE_SIDE    = crl_pkg::DEF_ACTIVE_SIDE,
  parameter int CHIPS_PER_SIDE = crl_pkg::DEF_CHIPS_PER_SIDE,
  parameter int QUEUE_DEPTH    = crl_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  crl_pkg::cmd_item_t    cmd,
  output logic                  empty,
  input  logic                  pop,
  output crl_pkg::result_item_t result,
  input  logic                  cfg_write,
  input  logic                  cfg_data
);

  import crl_pkg::*;

  localparam int POS_W = $clog2(CHIP_SIDE * CHIP_SIDE * CHIPS_PER_SIDE * CHIPS_PER_SIDE);

  logic             cmd_valid;
  cmd_ctl_t         cmd_ctl;
  logic [POS_W-1:0] cmd_pos;
  logic             cmd_pop;
  logic             res_push;
  logic             res_full;
  result_item_t     res_data;
  logic             sweeping;

  crl_front #(
    .CHIP_SIDE      (CHIP_SIDE),
    .CHIPS_PER_SIDE (CHIPS_PER_SIDE),
    .QUEUE_DEPTH    (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .cmd     (cmd),
    .hold    (sweeping),
    .q_valid (cmd_valid),
    .q_ctl   (cmd_ctl),
    .q_pos   (cmd_pos),
    .q_pop   (cmd_pop)
  );

  crl_back #(
    .CHIP_SIDE      (CHIP_SIDE),
    .ACTIVE_SIDE    (ACTIVE_SIDE),
    .CHIPS_PER_SIDE (CHIPS_PER_SIDE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_ctl   (cmd_ctl),
    .cmd_pos   (cmd_pos),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data),
    .sweeping  (sweeping)
  );

  crl_fifo #(
    .WIDTH ($bits(result_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_data),
    .full  (res_full),
    .pop   (pop),
    .dout  (result),
    .empty (empty)
  );

  `CRL_CHECK(a_res_no_overflow, res_push, !res_full, "result pushed into a full result queue")
  `CRL_CHECK_NEXT(a_cmd_queued, push && !full, cmd_valid, "accepted transaction not queued")
  `CRL_CHECK(a_idle_latch_high, res_push && !res_data.busy_res, res_data.latch_clock, "latch low while idle")
  `CRL_CHECK(a_sweep_blocks_input, sweeping, full, "transaction taken during the clearing pass")

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Crosspoint route loader testbench
// Drives command transactions into the route loader and checks each result
// against its typed expectation if any, else a cycle-free model of the route
// map and flush sequence. A short directed table comes first, then random
// rounds of map building and full flushes, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import crl_pkg::*;

  localparam int CHIP_SIDE     = DEF_CHIP_SIDE;
  localparam int ACTIVE_SIDE   = DEF_ACTIVE_SIDE;
  localparam int CHIPS         = DEF_CHIPS_PER_SIDE;
  localparam int GRID_SIDE     = CHIP_SIDE * CHIPS;
  localparam int CHIP_BITS     = CHIP_SIDE * CHIP_SIDE;
  localparam int MAP_BITS      = CHIP_BITS * CHIPS * CHIPS;

  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SOME = 1;
  localparam int IDLE_FULL = 2;

  localparam int MAX_GAP       = 13;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 200;
  localparam int CYCLE_LIMIT   = 4000000;
  localparam int MAX_REPORTS   = 100;
  localparam int RANDOM_ROUNDS = 6;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRESET,
    PH_ZEROS,
    PH_LATCH1,
    PH_DATA,
    PH_LATCH2
  } flush_phase_t;

  typedef enum bit {ROW_CMD, ROW_LINK} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    bit           link_val;
    cmd_item_t    item;
    bit           typed;
    result_item_t want;
  } plan_row_t;

  localparam result_item_t RES_IDLE = '{routed: 1'b0, busy_res: 1'b0, rejected: 1'b0,
                                        serial_clock: 1'b0, serial_data: 1'b0,
                                        latch_clock: 1'b1};
  localparam result_item_t RES_ROUTED = '{routed: 1'b1, busy_res: 1'b0, rejected: 1'b0,
                                          serial_clock: 1'b0, serial_data: 1'b0,
                                          latch_clock: 1'b1};
  localparam result_item_t RES_LINK_OFF = '{routed: 1'b0, busy_res: 1'b0, rejected: 1'b1,
                                            serial_clock: 1'b0, serial_data: 1'b0,
                                            latch_clock: 1'b1};
  localparam result_item_t RES_BUSY = '{routed: 1'b0, busy_res: 1'b1, rejected: 1'b0,
                                        serial_clock: 1'b0, serial_data: 1'b0,
                                        latch_clock: 1'b1};
  localparam result_item_t RES_BUSY_REJ = '{routed: 1'b0, busy_res: 1'b1, rejected: 1'b1,
                                            serial_clock: 1'b0, serial_data: 1'b0,
                                            latch_clock: 1'b1};

  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         push      = 1'b0;
  logic         full;
  cmd_item_t    cmd       = '0;
  logic         empty;
  logic         pop       = 1'b0;
  result_item_t result;
  logic         cfg_write = 1'b0;
  logic         cfg_data  = 1'b0;

  // Typed expectation that travels with the command being offered.
  bit           cmd_typed = 1'b0;
  result_item_t cmd_want  = '0;

  // Model of the route map, the flush sequencer and the pin levels.
  bit           route_map [MAP_BITS];
  flush_phase_t phase     = PH_IDLE;
  int unsigned  bit_cnt   = 0;
  int unsigned  step_cnt  = 0;
  bit           sck_lvl   = 1'b0;
  bit           sdi_lvl   = 1'b0;
  bit           lat_lvl   = 1'b1;
  bit           link_en   = 1'b0;

  result_item_t expected_q [$];
  cmd_item_t    added_q [$];
  int           error_count  = 0;
  int           result_count = 0;
  int unsigned  cycle_count  = 0;
  int           send_mode    = IDLE_SOME;
  int           recv_mode    = IDLE_SOME;
  bit           hold_req     = 1'b0;

  crosspoint_route_loader_unit dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .cmd(cmd),
    .empty(empty),
    .pop(pop),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int map_index(logic [4:0] col, logic [4:0] rw);
    int chip;
    chip = (rw / CHIP_SIDE) * CHIPS + col / CHIP_SIDE;
    return chip * CHIP_BITS + (rw % CHIP_SIDE) * CHIP_SIDE + col % CHIP_SIDE;
  endfunction

  function automatic void advance_flush();
    int unsigned pos;
    case (phase)
      PH_PRESET: begin
        sdi_lvl  = 1'b0;
        phase    = PH_ZEROS;
        step_cnt = 0;
        bit_cnt  = 0;
      end
      PH_ZEROS: begin
        sck_lvl = (step_cnt < 2);
        if (step_cnt == 3) begin
          step_cnt = 0;
          bit_cnt++;
          if (bit_cnt >= MAP_BITS) begin
            bit_cnt = 0;
            phase   = PH_LATCH1;
          end
        end else begin
          step_cnt++;
        end
      end
      PH_LATCH1, PH_LATCH2: begin
        if (step_cnt == 0) begin
          lat_lvl  = 1'b0;
          step_cnt = 1;
        end else begin
          lat_lvl  = 1'b1;
          step_cnt = 0;
          bit_cnt  = 0;
          phase    = (phase == PH_LATCH1) ? PH_DATA : PH_IDLE;
        end
      end
      PH_DATA: begin
        if (step_cnt == 0) begin
          // Bytes go out in order, each with its bit 7 first.
          pos      = (bit_cnt & ~32'd7) | (7 - (bit_cnt & 7));
          sdi_lvl  = route_map[pos];
          step_cnt = 1;
        end else if (step_cnt < 3) begin
          sck_lvl = 1'b1;
          step_cnt++;
        end else begin
          sck_lvl  = 1'b0;
          step_cnt = 0;
          bit_cnt++;
          if (bit_cnt >= MAP_BITS) begin
            bit_cnt = 0;
            phase   = PH_LATCH2;
          end
        end
      end
      default: phase = PH_IDLE;
    endcase
  endfunction

  function automatic result_item_t loader_step(cmd_item_t c);
    result_item_t r;
    bit           busy;
    bit           on_grid;
    int           pos;
    r       = '0;
    busy    = (phase != PH_IDLE);
    on_grid = (c.col_index < GRID_SIDE) && (c.row_index < GRID_SIDE);
    pos     = map_index(c.col_index, c.row_index);
    if (c.action == ACT_TICK) begin
      if (busy) advance_flush();
    end else if (c.action <= ACT_FLUSH && busy) begin
      r.rejected = 1'b1;
    end else if (c.action == ACT_ADD) begin
      if (on_grid) route_map[pos] = 1'b1;
    end else if (c.action == ACT_QUERY) begin
      if (on_grid) r.routed = route_map[pos];
    end else if (c.action == ACT_CLEAR) begin
      foreach (route_map[i]) route_map[i] = 1'b0;
    end else if (c.action == ACT_FLUSH) begin
      if (!link_en) begin
        r.rejected = 1'b1;
      end else begin
        // Crosspoints outside the active corner of each chip are dropped.
        foreach (route_map[i]) begin
          if ((i % CHIP_BITS) / CHIP_SIDE >= ACTIVE_SIDE || i % CHIP_SIDE >= ACTIVE_SIDE)
            route_map[i] = 1'b0;
        end
        phase    = PH_PRESET;
        bit_cnt  = 0;
        step_cnt = 0;
      end
    end
    r.busy_res     = (phase != PH_IDLE);
    r.serial_clock = sck_lvl;
    r.serial_data  = sdi_lvl;
    r.latch_clock  = lat_lvl;
    return r;
  endfunction

  task automatic report_error(string msg);
    if (error_count < MAX_REPORTS) $display("%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic got, logic want, int n);
    if (got !== want)
      report_error($sformatf("result %0d: %s is %b, expected %b", n, name, got, want));
  endtask

  // Results are checked before the command of the same edge is predicted, so
  // a transaction can never be matched against its own expectation.
  always @(posedge clk) begin : monitor
    result_item_t want;
    result_item_t predicted;
    if (!rst) begin
      if (pop && !empty) begin
        result_count++;
        if (expected_q.size() == 0) begin
          report_error($sformatf("result %0d arrived with no transaction pending",
                                 result_count));
        end else begin
          want = expected_q.pop_front();
          check_field("routed", result.routed, want.routed, result_count);
          check_field("busy_res", result.busy_res, want.busy_res, result_count);
          check_field("rejected", result.rejected, want.rejected, result_count);
          check_field("serial_clock", result.serial_clock, want.serial_clock, result_count);
          check_field("serial_data", result.serial_data, want.serial_data, result_count);
          check_field("latch_clock", result.latch_clock, want.latch_clock, result_count);
        end
      end
      if (push && !full) begin
        predicted = loader_step(cmd);
        expected_q.push_back(cmd_typed ? cmd_want : predicted);
      end
      if (cfg_write) link_en = cfg_data;
    end
  end

  function automatic int draw_gap(int mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
      default:   return $urandom_range(0, MAX_GAP);
    endcase
  endfunction

  function automatic cmd_item_t make_cmd(logic [2:0] act, logic [4:0] col, logic [4:0] rw);
    cmd_item_t c;
    c.action    = act;
    c.col_index = col;
    c.row_index = rw;
    return c;
  endfunction

  function automatic plan_row_t plan_entry(logic [2:0] act, logic [4:0] col, logic [4:0] rw,
                                           bit typed, result_item_t want);
    plan_row_t p;
    p          = '0;
    p.kind     = ROW_CMD;
    p.item     = make_cmd(act, col, rw);
    p.typed    = typed;
    p.want     = want;
    return p;
  endfunction

  task automatic send_item(cmd_item_t c, bit typed, result_item_t want);
    int gap;
    gap = draw_gap(send_mode);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push      <= 1'b1;
    cmd       <= c;
    cmd_typed <= typed;
    cmd_want  <= want;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random(logic [2:0] act);
    send_item(make_cmd(act, 5'($urandom_range(0, GRID_SIDE - 1)),
                       5'($urandom_range(0, GRID_SIDE - 1))),
              1'b0, '0);
  endtask

  task automatic wait_results();
    push <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    // A clear or flush start may still be sweeping the map after its result.
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_link(bit value);
    wait_results();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Ticks the flush through to its end, with the odd command mixed in while busy.
  task automatic finish_flush();
    logic [2:0] act;
    while (phase != PH_IDLE) begin
      act = 3'($urandom_range(ACT_ADD, ACT_SPARE_HI));
      if ($urandom_range(0, 99) < 96) send_random(ACT_TICK);
      else send_random(act);
    end
  endtask

  task automatic build_map(int count);
    int        pick;
    cmd_item_t c;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      c = make_cmd(ACT_ADD, 5'($urandom_range(0, GRID_SIDE - 1)),
                   5'($urandom_range(0, GRID_SIDE - 1)));
      if (pick < 50) begin
        added_q.push_back(c);
      end else if (pick < 80) begin
        if (added_q.size() != 0 && pick < 65) c = added_q[$urandom_range(0, added_q.size() - 1)];
        c.action = ACT_QUERY;
      end else if (pick < 85) begin
        c.action = ACT_TICK;
      end else if (pick < 90) begin
        c.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
      end else if (pick < 93) begin
        c.action = ACT_CLEAR;
        added_q.delete();
      end else if (pick < 96) begin
        // With the link up a flush start would begin a full flush here.
        c.action = link_en ? ACT_QUERY : ACT_FLUSH;
      end else begin
        c.col_index = $urandom_range(0, 1) ? 5'(GRID_SIDE - 1) : 5'd0;
        c.row_index = $urandom_range(0, 1) ? 5'(GRID_SIDE - 1) : 5'd0;
        added_q.push_back(c);
      end
      send_item(c, 1'b0, '0);
    end
  endtask

  initial begin : result_drain
    int gap;
    while (rst) @(negedge clk);
    forever begin
      gap = draw_gap(recv_mode);
      if (hold_req) begin
        gap      = gap + HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[crosspoint_route_loader_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    plan_row_t plan [$];
    plan_row_t link_row;
    int        round;

    plan.push_back(plan_entry(ACT_QUERY, 0, 0, 1'b1, RES_IDLE));
    plan.push_back(plan_entry(ACT_TICK, 31, 31, 1'b1, RES_IDLE));
    plan.push_back(plan_entry(ACT_FLUSH, 0, 0, 1'b1, RES_LINK_OFF));
    plan.push_back(plan_entry(ACT_ADD, 0, 0, 1'b1, RES_IDLE));
    plan.push_back(plan_entry(ACT_ADD, 31, 31, 1'b1, RES_IDLE));
    plan.push_back(plan_entry(ACT_ADD, 31, 0, 1'b1, RES_IDLE));
    plan.push_back(plan_entry(ACT_ADD, 0, 31, 1'b1, RES_IDLE));
    plan.push_back(plan_entry(ACT_QUERY, 0, 0, 1'b1, RES_ROUTED));
    plan.push_back(plan_entry(ACT_QUERY, 31, 31, 1'b1, RES_ROUTED));
    plan.push_back(plan_entry(ACT_QUERY, 31, 0, 1'b1, RES_ROUTED));
    plan.push_back(plan_entry(ACT_QUERY, 0, 31, 1'b1, RES_ROUTED));
    plan.push_back(plan_entry(ACT_QUERY, 1, 0, 1'b1, RES_IDLE));
    plan.push_back(plan_entry(ACT_SPARE_LO, 31, 31, 1'b1, RES_IDLE));
    plan.push_back(plan_entry(ACT_SPARE_HI, 0, 0, 1'b1, RES_IDLE));
    plan.push_back(plan_entry(ACT_CLEAR, 0, 0, 1'b1, RES_IDLE));
    plan.push_back(plan_entry(ACT_QUERY, 31, 31, 1'b1, RES_IDLE));
    // Column 12 is outside the active corner; it stays set until a flush starts.
    plan.push_back(plan_entry(ACT_ADD, 12, 3, 1'b1, RES_IDLE));
    plan.push_back(plan_entry(ACT_QUERY, 12, 3, 1'b1, RES_ROUTED));
    plan.push_back(plan_entry(ACT_ADD, 5, 9, 1'b1, RES_IDLE));
    plan.push_back(plan_entry(ACT_ADD, 27, 20, 1'b1, RES_IDLE));
    link_row          = '0;
    link_row.kind     = ROW_LINK;
    link_row.link_val = 1'b1;
    plan.push_back(link_row);
    plan.push_back(plan_entry(ACT_FLUSH, 7, 7, 1'b1, RES_BUSY));
    plan.push_back(plan_entry(ACT_ADD, 1, 1, 1'b1, RES_BUSY_REJ));
    plan.push_back(plan_entry(ACT_QUERY, 27, 20, 1'b1, RES_BUSY_REJ));
    plan.push_back(plan_entry(ACT_CLEAR, 0, 0, 1'b1, RES_BUSY_REJ));
    plan.push_back(plan_entry(ACT_FLUSH, 0, 0, 1'b1, RES_BUSY_REJ));
    plan.push_back(plan_entry(ACT_SPARE_LO, 0, 0, 1'b1, RES_BUSY));
    plan.push_back(plan_entry(ACT_TICK, 0, 0, 1'b1, RES_BUSY));
    plan.push_back(plan_entry(ACT_TICK, 0, 0, 1'b0, '0));

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_LINK) write_link(plan[i].link_val);
      else send_item(plan[i].item, plan[i].typed, plan[i].want);
    end
    finish_flush();

    for (round = 0; round < RANDOM_ROUNDS; round++) begin
      write_link(round % 3 != 1);
      send_mode = $urandom_range(IDLE_NONE, IDLE_FULL);
      recv_mode = $urandom_range(IDLE_NONE, IDLE_FULL);
      if (round == 1) begin
        // The receiver stops for a long stretch while commands keep coming.
        send_mode = IDLE_NONE;
        hold_req  = 1'b1;
      end
      if (round == 3) begin
        send_mode = IDLE_FULL;
        recv_mode = IDLE_FULL;
      end
      build_map($urandom_range(250, 330));
      if (round == 0 || round == 3) begin
        send_random(ACT_FLUSH);
        finish_flush();
      end
    end

    wait_results();
    if (error_count == 0) begin
      $display("[crosspoint_route_loader_unit] OK");
    end else begin
      $display("[crosspoint_route_loader_unit] ERROR");
    end
    $finish;
  end

endmodule
